FILE: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define IRFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset cycles included.
`define IRFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/irfc_pkg.sv
package irfc_pkg;

  localparam int TAPS     = 51;
  localparam int CHANNELS = 4;
  localparam int NUM_IN   = 4;
  localparam int NCH      = (CHANNELS < NUM_IN) ? CHANNELS : NUM_IN;

  localparam int SAMPLE_W = 12;
  localparam int DIST_W   = 7;

  localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FILL_W    = $clog2(TAPS + 1);
  localparam int CH_W      = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int MEM_DEPTH = NCH * TAPS;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int NUM_COEF   = 51;
  localparam int COEF_IDX_W = $clog2(NUM_COEF);
  localparam int COEF_W     = 15;
  localparam int PROD_W     = COEF_W + SAMPLE_W + 1;
  localparam int ACC_W      = 32;
  localparam int SCALE_SH   = 14;
  localparam int SAT_MAX    = 4095;

  localparam int DRAIN_CYCLES = 2;
  localparam int DRAIN_W      = (DRAIN_CYCLES > 1) ? $clog2(DRAIN_CYCLES) : 1;

  localparam int CAL_POINTS = 13;
  localparam int CAL_IDX_W  = $clog2(CAL_POINTS + 1);
  localparam int REM_W      = 13;
  localparam int QUO_W      = 3;

  localparam logic [DIST_W-1:0] DIST_MIN  = DIST_W'(10);
  localparam logic [DIST_W-1:0] DIST_MAX  = DIST_W'(70);
  localparam logic [DIST_W-1:0] DIST_STEP = DIST_W'(5);

  localparam logic signed [COEF_W-1:0] FIR_COEF [NUM_COEF] = '{
    -15'sd11, 15'sd10, 15'sd9, -15'sd5, 15'sd1, 15'sd0, -15'sd19, 15'sd6, 15'sd48,
    -15'sd12, -15'sd92, 15'sd17, 15'sd155, -15'sd20, -15'sd243, 15'sd22, 15'sd370,
    -15'sd24, -15'sd559, 15'sd24, 15'sd881, -15'sd24, -15'sd1584, 15'sd24,
    15'sd4932, 15'sd8578, 15'sd4932, 15'sd24, -15'sd1584, -15'sd24, 15'sd881,
    15'sd24, -15'sd559, -15'sd24, 15'sd370, 15'sd22, -15'sd243, -15'sd20,
    15'sd155, 15'sd17, -15'sd92, -15'sd12, 15'sd48, 15'sd6, -15'sd19, 15'sd0,
    15'sd1, -15'sd5, 15'sd9, 15'sd10, -15'sd11
  };

  localparam logic [SAMPLE_W-1:0] CAL_PTS [CAL_POINTS] = '{
    12'd2930, 12'd2020, 12'd1600, 12'd1300, 12'd1110, 12'd980, 12'd860,
    12'd780, 12'd720, 12'd660, 12'd620, 12'd560, 12'd540
  };

  function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] i);
    if (int'(i) < NUM_COEF) begin
      return FIR_COEF[i];
    end
    return '0;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_CAL_START,
    ST_CAL_WAIT,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    CAL_IDLE,
    CAL_SETUP,
    CAL_ITER
  } cal_phase_t;

  typedef struct packed {
    logic             take;
    logic             wr;
    logic             rd;
    logic             acc_clr;
    logic             cal_start;
    logic             store;
    logic             emit;
    logic [TAP_W-1:0] tap;
    logic [CH_W-1:0]  ch;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic cal_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/irfc_if.sv
interface irfc_in_if;
  logic                          valid;
  logic                          ready;
  logic [irfc_pkg::SAMPLE_W-1:0] sample_ch0;
  logic [irfc_pkg::SAMPLE_W-1:0] sample_ch1;
  logic [irfc_pkg::SAMPLE_W-1:0] sample_ch2;
  logic [irfc_pkg::SAMPLE_W-1:0] sample_ch3;

  modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  input ready);
  modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                output ready);
endinterface

interface irfc_out_if;
  logic                        valid;
  logic                        ready;
  logic [irfc_pkg::DIST_W-1:0] distance_ch0;
  logic [irfc_pkg::DIST_W-1:0] distance_ch1;
  logic [irfc_pkg::DIST_W-1:0] distance_ch2;
  logic [irfc_pkg::DIST_W-1:0] distance_ch3;

  modport source (output valid, distance_ch0, distance_ch1, distance_ch2, distance_ch3,
                  input ready);
  modport sink (input valid, distance_ch0, distance_ch1, distance_ch2, distance_ch3,
                output ready);
endinterface

FILE: src/irfc_cal.sv
module irfc_cal (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [irfc_pkg::ACC_W-1:0]  acc,
  output logic                               done,
  output logic        [irfc_pkg::DIST_W-1:0] distance
);

  irfc_pkg::cal_phase_t phase, phase_next;

  logic [irfc_pkg::SAMPLE_W-1:0]  v;
  logic [irfc_pkg::SAMPLE_W-1:0]  v_sat;
  logic [irfc_pkg::ACC_W-irfc_pkg::SCALE_SH-1:0] quot;
  logic [irfc_pkg::CAL_IDX_W-1:0] pos;
  logic [irfc_pkg::CAL_IDX_W-1:0] hi_idx;
  logic [irfc_pkg::CAL_IDX_W-1:0] lo_idx;
  logic [irfc_pkg::SAMPLE_W-1:0]  hi;
  logic [irfc_pkg::SAMPLE_W-1:0]  lo;
  logic [irfc_pkg::REM_W-1:0]     diff;
  logic [irfc_pkg::REM_W-1:0]     rem;
  logic [irfc_pkg::REM_W-1:0]     divisor;
  logic [irfc_pkg::DIST_W-1:0]    base;
  logic [irfc_pkg::QUO_W-1:0]     q;
  logic                           setup_edge;
  logic                           rem_ge;

  // truncation toward zero: any negative sum ends at zero after the clamp
  always_comb begin
    quot = acc[irfc_pkg::ACC_W-1:irfc_pkg::SCALE_SH];
    if (acc[irfc_pkg::ACC_W-1]) begin
      v_sat = '0;
    end else if (quot > (irfc_pkg::ACC_W-irfc_pkg::SCALE_SH)'(irfc_pkg::SAT_MAX)) begin
      v_sat = irfc_pkg::SAMPLE_W'(irfc_pkg::SAT_MAX);
    end else begin
      v_sat = quot[irfc_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    pos = '0;
    for (int k = 0; k < irfc_pkg::CAL_POINTS; k++) begin
      pos = pos + irfc_pkg::CAL_IDX_W'(v <= irfc_pkg::CAL_PTS[k]);
    end
    setup_edge = (pos == '0) || (pos == irfc_pkg::CAL_IDX_W'(irfc_pkg::CAL_POINTS));
    hi_idx     = (pos == '0) ? '0 : pos - 1'b1;
    lo_idx     = setup_edge ? '0 : pos;
    hi         = irfc_pkg::CAL_PTS[hi_idx];
    lo         = irfc_pkg::CAL_PTS[lo_idx];
    diff       = irfc_pkg::REM_W'(hi - v);
    rem_ge     = rem >= divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= irfc_pkg::CAL_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      irfc_pkg::CAL_IDLE:  if (start) phase_next = irfc_pkg::CAL_SETUP;
      irfc_pkg::CAL_SETUP: phase_next = setup_edge ? irfc_pkg::CAL_IDLE : irfc_pkg::CAL_ITER;
      irfc_pkg::CAL_ITER:  if (!rem_ge) phase_next = irfc_pkg::CAL_IDLE;
      default:             phase_next = irfc_pkg::CAL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((phase == irfc_pkg::CAL_SETUP) && setup_edge) ||
              ((phase == irfc_pkg::CAL_ITER) && !rem_ge);
    end
  end

  // 5*(hi-v)/(hi-lo) by repeated subtraction; the quotient never exceeds 4
  always_ff @(posedge clk) begin
    case (phase)
      irfc_pkg::CAL_IDLE: begin
        if (start) v <= v_sat;
      end
      irfc_pkg::CAL_SETUP: begin
        if (pos == '0) begin
          distance <= irfc_pkg::DIST_MIN;
        end else if (setup_edge) begin
          distance <= irfc_pkg::DIST_MAX;
        end
        rem     <= (diff << 2) + diff;
        divisor <= irfc_pkg::REM_W'(hi - lo);
        base    <= irfc_pkg::DIST_MIN +
                   irfc_pkg::DIST_W'(irfc_pkg::DIST_STEP * irfc_pkg::DIST_W'(hi_idx));
        q       <= '0;
      end
      irfc_pkg::CAL_ITER: begin
        if (rem_ge) begin
          rem <= rem - divisor;
          q   <= q + 1'b1;
        end else begin
          distance <= base + irfc_pkg::DIST_W'(q);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: src/irfc_dp.sv
module irfc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  irfc_pkg::dp_cmd_t    cmd,
  output irfc_pkg::dp_status_t status,
  irfc_in_if.sink              samples,
  irfc_out_if.source           distances
);

  logic [irfc_pkg::SAMPLE_W-1:0] in_vec  [irfc_pkg::NUM_IN];
  logic [irfc_pkg::SAMPLE_W-1:0] lat     [irfc_pkg::NCH];
  logic [irfc_pkg::DIST_W-1:0]   res     [irfc_pkg::NCH];
  logic [irfc_pkg::DIST_W-1:0]   out_dist [irfc_pkg::NUM_IN];
  logic [irfc_pkg::SAMPLE_W-1:0] hist    [irfc_pkg::MEM_DEPTH];

  logic [irfc_pkg::TAP_W-1:0]    wp;
  logic [irfc_pkg::FILL_W-1:0]   fill;
  logic [irfc_pkg::TAP_W:0]      slot_w;
  logic [irfc_pkg::TAP_W-1:0]    slot;
  logic [irfc_pkg::ADDR_W-1:0]   ch_base;
  logic [irfc_pkg::ADDR_W-1:0]   rd_addr;
  logic [irfc_pkg::ADDR_W-1:0]   wr_addr;
  logic                          accept;
  logic                          out_valid;

  logic [irfc_pkg::SAMPLE_W-1:0]      rd_data;
  logic                               s1_vld;
  logic                               s1_live;
  logic signed [irfc_pkg::COEF_W-1:0] s1_coef;
  logic                               s2_vld;
  logic signed [irfc_pkg::PROD_W-1:0] prod;
  logic signed [irfc_pkg::ACC_W-1:0]  acc;

  logic                          cal_done;
  logic [irfc_pkg::DIST_W-1:0]   cal_dist;

  assign in_vec[0] = samples.sample_ch0;
  assign in_vec[1] = samples.sample_ch1;
  assign in_vec[2] = samples.sample_ch2;
  assign in_vec[3] = samples.sample_ch3;

  assign samples.ready = cmd.take;
  assign accept        = samples.valid && cmd.take;

  assign status.in_valid = samples.valid;
  assign status.cal_done = cal_done;
  assign status.out_free = !out_valid || distances.ready;

  always_comb begin
    if (wp >= cmd.tap) begin
      slot_w = {1'b0, wp} - {1'b0, cmd.tap};
    end else begin
      slot_w = {1'b0, wp} + (irfc_pkg::TAP_W+1)'(irfc_pkg::TAPS) - {1'b0, cmd.tap};
    end
    slot    = slot_w[irfc_pkg::TAP_W-1:0];
    ch_base = irfc_pkg::ADDR_W'(irfc_pkg::ADDR_W'(cmd.ch) *
                                irfc_pkg::ADDR_W'(irfc_pkg::TAPS));
    rd_addr = ch_base + irfc_pkg::ADDR_W'(slot);
    wr_addr = ch_base + irfc_pkg::ADDR_W'(wp);
  end

  // ring pointer and fill count; slots older than the fill count read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= irfc_pkg::TAP_W'(irfc_pkg::TAPS - 1);
      fill <= '0;
    end else if (accept) begin
      wp   <= (wp == irfc_pkg::TAP_W'(irfc_pkg::TAPS - 1)) ? '0 : wp + 1'b1;
      if (fill != irfc_pkg::FILL_W'(irfc_pkg::TAPS)) fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int c = 0; c < irfc_pkg::NCH; c++) begin
        lat[c] <= in_vec[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) hist[wr_addr] <= lat[cmd.ch];
    if (cmd.rd) rd_data <= hist[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= cmd.rd;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_live <= irfc_pkg::FILL_W'(cmd.tap) < fill;
    s1_coef <= irfc_pkg::coef_at(irfc_pkg::COEF_IDX_W'(cmd.tap));
    prod    <= s1_coef * $signed({1'b0, (s1_live ? rd_data : '0)});
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (s2_vld) begin
      acc <= acc + irfc_pkg::ACC_W'(prod);
    end
  end

  irfc_cal u_cal (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.cal_start),
    .acc      (acc),
    .done     (cal_done),
    .distance (cal_dist)
  );

  always_ff @(posedge clk) begin
    if (cmd.store) res[cmd.ch] <= cal_dist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (distances.ready) begin
      out_valid <= 1'b0;
    end
  end

  // channels that are not kept report the distance for a zero reading
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      for (int c = 0; c < irfc_pkg::NUM_IN; c++) begin
        if (c < irfc_pkg::NCH) begin
          out_dist[c] <= res[c];
        end else begin
          out_dist[c] <= irfc_pkg::DIST_MAX;
        end
      end
    end
  end

  assign distances.valid        = out_valid;
  assign distances.distance_ch0 = out_dist[0];
  assign distances.distance_ch1 = out_dist[1];
  assign distances.distance_ch2 = out_dist[2];
  assign distances.distance_ch3 = out_dist[3];

endmodule

FILE: src/irfc_ctrl.sv
module irfc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  irfc_pkg::dp_status_t status,
  output irfc_pkg::dp_cmd_t    cmd
);

  irfc_pkg::ctrl_state_t state, state_next;

  logic [irfc_pkg::TAP_W-1:0]   tap, tap_next;
  logic [irfc_pkg::CH_W-1:0]    ch, ch_next;
  logic [irfc_pkg::DRAIN_W-1:0] drain, drain_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irfc_pkg::ST_IDLE;
      tap   <= '0;
      ch    <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
      ch    <= ch_next;
      drain <= drain_next;
    end
  end

  always_comb begin
    state_next    = state;
    tap_next      = tap;
    ch_next       = ch;
    drain_next    = drain;
    cmd           = '0;
    cmd.tap       = tap;
    cmd.ch        = ch;
    case (state)
      irfc_pkg::ST_IDLE: begin
        cmd.take = 1'b1;
        if (status.in_valid) begin
          ch_next    = '0;
          state_next = irfc_pkg::ST_WRITE;
        end
      end
      irfc_pkg::ST_WRITE: begin
        cmd.wr      = 1'b1;
        cmd.acc_clr = 1'b1;
        tap_next    = '0;
        state_next  = irfc_pkg::ST_READ;
      end
      irfc_pkg::ST_READ: begin
        cmd.rd = 1'b1;
        if (tap == irfc_pkg::TAP_W'(irfc_pkg::TAPS - 1)) begin
          drain_next = '0;
          state_next = irfc_pkg::ST_DRAIN;
        end else begin
          tap_next = tap + 1'b1;
        end
      end
      irfc_pkg::ST_DRAIN: begin
        if (drain == irfc_pkg::DRAIN_W'(irfc_pkg::DRAIN_CYCLES - 1)) begin
          state_next = irfc_pkg::ST_CAL_START;
        end else begin
          drain_next = drain + 1'b1;
        end
      end
      irfc_pkg::ST_CAL_START: begin
        cmd.cal_start = 1'b1;
        state_next    = irfc_pkg::ST_CAL_WAIT;
      end
      irfc_pkg::ST_CAL_WAIT: begin
        if (status.cal_done) begin
          cmd.store = 1'b1;
          if (ch == irfc_pkg::CH_W'(irfc_pkg::NCH - 1)) begin
            state_next = irfc_pkg::ST_FINISH;
          end else begin
            ch_next    = ch + 1'b1;
            state_next = irfc_pkg::ST_WRITE;
          end
        end
      end
      irfc_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = irfc_pkg::ST_IDLE;
        end
      end
      default: state_next = irfc_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: src/ir_range_fir_calibrate_top.sv
// channel    dir  payload                        handshake
// samples    in   sample_ch0..3, 12 b unsigned   valid/ready
// distances  out  distance_ch0..3, 7 b, 10..70   valid/ready
//
// One item passes through these steps: the accept, then per channel one history
// write, TAPS reads through the ring memory into one MAC, a pipeline drain, the
// start and the interpolation divide and store, and finally the hand-over of the
// result.
// rst is synchronous; history reads as zero until TAPS items have been taken.
// A new item is taken while a finished result waits; if the previous result is
// still held at the end of the next item, that item stalls until it is taken.
module ir_range_fir_calibrate_top (
  input logic        clk,
  input logic        rst,
  irfc_in_if.sink    samples,
  irfc_out_if.source distances
);

  irfc_pkg::dp_cmd_t    cmd;
  irfc_pkg::dp_status_t status;

  irfc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  irfc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .samples   (samples),
    .distances (distances)
  );

endmodule

FILE: src/irfc_checker.sv
`include "assert_macros.svh"

module irfc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [irfc_pkg::DIST_W-1:0] d0,
  input logic [irfc_pkg::DIST_W-1:0] d1,
  input logic [irfc_pkg::DIST_W-1:0] d2,
  input logic [irfc_pkg::DIST_W-1:0] d3
);

  logic in_range;

  assign in_range = d0 >= irfc_pkg::DIST_MIN && d0 <= irfc_pkg::DIST_MAX &&
                    d1 >= irfc_pkg::DIST_MIN && d1 <= irfc_pkg::DIST_MAX &&
                    d2 >= irfc_pkg::DIST_MIN && d2 <= irfc_pkg::DIST_MAX &&
                    d3 >= irfc_pkg::DIST_MIN && d3 <= irfc_pkg::DIST_MAX;

  `IRFC_ASSERT_ALWAYS(a_out_idle_after_reset, rst |=> !out_valid, "result valid after reset")

  `IRFC_ASSERT(a_busy_after_take, (in_valid && in_ready) |=> !in_ready, "ready held after item taken")

  `IRFC_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")

  `IRFC_ASSERT(a_dist_range, out_valid |-> in_range, "distance out of range")

endmodule

bind ir_range_fir_calibrate_top irfc_checker u_irfc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (distances.valid),
  .out_ready (distances.ready),
  .d0        (distances.distance_ch0),
  .d1        (distances.distance_ch1),
  .d2        (distances.distance_ch2),
  .d3        (distances.distance_ch3)
);
